>>> rtl/crtc_pkg.sv
`timescale 1ns / 1ps

package crtc_pkg;

  // storage depth default
  localparam int REG_COUNT_DEF = 64;

  // index register keeps six bits
  localparam int IDX_W = 6;

  // register file addresses with special read or write behaviour
  localparam logic [IDX_W-1:0] REG_SECONDS  = 6'h00;
  localparam logic [IDX_W-1:0] REG_ALARM_S  = 6'h01;
  localparam logic [IDX_W-1:0] REG_MINUTES  = 6'h02;
  localparam logic [IDX_W-1:0] REG_ALARM_M  = 6'h03;
  localparam logic [IDX_W-1:0] REG_HOURS    = 6'h04;
  localparam logic [IDX_W-1:0] REG_ALARM_H  = 6'h05;
  localparam logic [IDX_W-1:0] REG_WEEKDAY  = 6'h06;
  localparam logic [IDX_W-1:0] REG_DAY      = 6'h07;
  localparam logic [IDX_W-1:0] REG_MONTH    = 6'h08;
  localparam logic [IDX_W-1:0] REG_YEAR     = 6'h09;
  localparam logic [IDX_W-1:0] REG_STATUS_A = 6'h0A;
  localparam logic [IDX_W-1:0] REG_STATUS_B = 6'h0B;
  localparam logic [IDX_W-1:0] REG_STATUS_C = 6'h0C;
  localparam logic [IDX_W-1:0] REG_STATUS_D = 6'h0D;
  localparam logic [IDX_W-1:0] REG_DIAG     = 6'h0E;
  localparam logic [IDX_W-1:0] REG_FLOPPY   = 6'h10;
  localparam logic [IDX_W-1:0] REG_DISK     = 6'h12;
  localparam logic [IDX_W-1:0] REG_EQUIP    = 6'h14;
  localparam logic [IDX_W-1:0] REG_BASE_LO  = 6'h15;
  localparam logic [IDX_W-1:0] REG_BASE_HI  = 6'h16;
  localparam logic [IDX_W-1:0] REG_EXT_LO   = 6'h17;
  localparam logic [IDX_W-1:0] REG_EXT_HI   = 6'h18;
  localparam logic [IDX_W-1:0] REG_DISK_C   = 6'h19;
  localparam logic [IDX_W-1:0] REG_DISK_D   = 6'h1A;
  localparam logic [IDX_W-1:0] REG_CENTURY  = 6'h33;

  // default bytes that do not follow from configuration
  localparam logic [7:0] DEF_STATUS_A = 8'h26;
  localparam logic [7:0] DEF_STATUS_B = 8'h02;
  localparam logic [7:0] DEF_STATUS_C = 8'h50;
  localparam logic [7:0] DEF_STATUS_D = 8'h80;
  localparam logic [7:0] DEF_DIAG     = 8'h00;
  localparam logic [7:0] DEF_DISK_TYP = 8'd47;
  localparam logic [7:0] DEF_CENTURY  = 8'hE1;

  // load-defaults sweep
  localparam int DEFAULT_COUNT  = 15;
  localparam int DEFAULT_STEP_W = 4;

  // configuration register indexes
  localparam logic [2:0] CFG_FLOPPY_COUNT = 3'd0;
  localparam logic [2:0] CFG_FLOPPY_A     = 3'd1;
  localparam logic [2:0] CFG_FLOPPY_B     = 3'd2;
  localparam logic [2:0] CFG_DISK_COUNT   = 3'd3;
  localparam logic [2:0] CFG_BASE_MEM     = 3'd4;
  localparam logic [2:0] CFG_EXT_MEM      = 3'd5;
  localparam logic [2:0] CFG_COPRO        = 3'd6;

  localparam logic [15:0] BASE_MEM_RESET = 16'd640;

  typedef enum logic [1:0] {
    CMD_INDEX = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_LOAD  = 2'd3
  } crtc_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } crtc_state_t;

  // how a read of a register is resolved
  typedef enum logic [1:0] {
    RK_CLOCK,
    RK_ALARM,
    RK_DATE,
    RK_PLAIN
  } crtc_rd_kind_t;

  typedef struct packed {
    logic [2:0]  floppy_count;
    logic [3:0]  floppy_a_type;
    logic [3:0]  floppy_b_type;
    logic [2:0]  disk_count;
    logic [15:0] base_mem_kb;
    logic [15:0] ext_mem_kb;
    logic        coprocessor_present;
  } crtc_cfg_t;

  // address written at each step of the defaults sweep
  function automatic logic [IDX_W-1:0] default_addr(input logic [DEFAULT_STEP_W-1:0] step);
    logic [IDX_W-1:0] a;
    case (step)
      4'd0:    a = REG_FLOPPY;
      4'd1:    a = REG_EQUIP;
      4'd2:    a = REG_DISK;
      4'd3:    a = REG_DISK_C;
      4'd4:    a = REG_DISK_D;
      4'd5:    a = REG_STATUS_A;
      4'd6:    a = REG_STATUS_B;
      4'd7:    a = REG_STATUS_C;
      4'd8:    a = REG_STATUS_D;
      4'd9:    a = REG_DIAG;
      4'd10:   a = REG_BASE_LO;
      4'd11:   a = REG_BASE_HI;
      4'd12:   a = REG_EXT_LO;
      4'd13:   a = REG_EXT_HI;
      4'd14:   a = REG_CENTURY;
      default: a = REG_SECONDS;
    endcase
    return a;
  endfunction

  // byte written at each step of the defaults sweep
  function automatic logic [7:0] default_byte(input logic [DEFAULT_STEP_W-1:0] step,
                                              input crtc_cfg_t cfg);
    logic [7:0] b;
    logic [2:0] fc_m1;
    logic [1:0] drives;
    logic       fc_nz;
    fc_nz  = (cfg.floppy_count != 3'd0);
    fc_m1  = fc_nz ? (cfg.floppy_count - 3'd1) : 3'd0;
    drives = (fc_m1 > 3'd3) ? 2'd3 : fc_m1[1:0];
    case (step)
      4'd0:    b = {fc_nz ? cfg.floppy_a_type : 4'h0,
                    (cfg.floppy_count > 3'd1) ? cfg.floppy_b_type : 4'h0};
      4'd1:    b = {drives, 4'b0000, cfg.coprocessor_present, fc_nz};
      4'd2:    b = {(cfg.disk_count != 3'd0) ? 4'hF : 4'h0,
                    (cfg.disk_count > 3'd1) ? 4'hF : 4'h0};
      4'd3:    b = DEF_DISK_TYP;
      4'd4:    b = DEF_DISK_TYP;
      4'd5:    b = DEF_STATUS_A;
      4'd6:    b = DEF_STATUS_B;
      4'd7:    b = DEF_STATUS_C;
      4'd8:    b = DEF_STATUS_D;
      4'd9:    b = DEF_DIAG;
      4'd10:   b = cfg.base_mem_kb[7:0];
      4'd11:   b = cfg.base_mem_kb[15:8];
      4'd12:   b = cfg.ext_mem_kb[7:0];
      4'd13:   b = cfg.ext_mem_kb[15:8];
      4'd14:   b = DEF_CENTURY;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/crtc_in_if.sv
`timescale 1ns / 1ps

interface crtc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data;
  logic [5:0] time_seconds;
  logic [5:0] time_minutes;
  logic [4:0] time_hours;
  logic [2:0] time_weekday;
  logic [4:0] time_day;
  logic [3:0] time_month;
  logic [7:0] time_year;

  modport source (
    output valid, command, data, time_seconds, time_minutes, time_hours,
           time_weekday, time_day, time_month, time_year,
    input  ready
  );

  modport sink (
    input  valid, command, data, time_seconds, time_minutes, time_hours,
           time_weekday, time_day, time_month, time_year,
    output ready
  );
endinterface

>>> rtl/crtc_out_if.sv
`timescale 1ns / 1ps

interface crtc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       unbacked;

  modport source (
    output valid, read_data, unbacked,
    input  ready
  );

  modport sink (
    input  valid, read_data, unbacked,
    output ready
  );
endinterface

>>> rtl/crtc_ram.sv
`timescale 1ns / 1ps

module crtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/crtc_ctrl.sv
`timescale 1ns / 1ps

module crtc_ctrl
  import crtc_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF,
  localparam int AW       = $clog2(REG_COUNT)
) (
  input  logic             clk,
  input  logic             rst_n,
  crtc_in_if.sink          in_ch,
  crtc_out_if.source       out_ch,
  input  crtc_cfg_t        cfg,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic [AW-1:0]    ram_raddr,
  input  logic [7:0]       ram_rdata
);

  crtc_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]         index_r, index_nxt;
  logic [REG_COUNT-1:0]     marks_r, marks_nxt;
  logic [DEFAULT_STEP_W-1:0] step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_data_r, out_data_nxt;
  logic                     out_unb_r, out_unb_nxt;
  crtc_rd_kind_t            kind_r, kind_nxt;
  logic [7:0]               tbyte_r, tbyte_nxt;

  logic [REG_COUNT-1:0]     default_marks;
  logic [AW-1:0]            idx_a;
  logic                     in_fire;
  logic                     ro_reg;
  crtc_cmd_t                cmd;

  assign idx_a     = AW'(index_r);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign cmd       = crtc_cmd_t'(in_ch.command);
  assign ro_reg    = (index_r == REG_STATUS_C) || (index_r == REG_STATUS_D);
  assign ram_raddr = idx_a;

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.unbacked  = out_unb_r;

  // marks left set by a defaults load
  always_comb begin
    default_marks = '0;
    for (int i = 0; i < DEFAULT_COUNT; i++) begin
      default_marks[AW'(default_addr(DEFAULT_STEP_W'(i)))] = 1'b1;
    end
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      index_r     <= '0;
      marks_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      index_r     <= index_nxt;
      marks_r     <= marks_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_unb_r  <= out_unb_nxt;
    kind_r     <= kind_nxt;
    tbyte_r    <= tbyte_nxt;
  end

  // next state, memory accesses and result
  always_comb begin
    state_nxt     = state_r;
    index_nxt     = index_r;
    marks_nxt     = marks_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_unb_nxt   = out_unb_r;
    kind_nxt      = kind_r;
    tbyte_nxt     = tbyte_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_a;
    ram_wdata     = in_ch.data;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_INDEX: begin
              index_nxt = in_ch.data[IDX_W-1:0];
            end
            CMD_WRITE: begin
              if (!ro_reg) begin
                ram_we           = 1'b1;
                marks_nxt[idx_a] = 1'b1;
              end
            end
            CMD_READ: begin
              // classify the register and capture the live time byte
              tbyte_nxt = 8'h00;
              case (index_r)
                REG_SECONDS: begin
                  kind_nxt  = RK_CLOCK;
                  tbyte_nxt = {2'b00, in_ch.time_seconds};
                end
                REG_MINUTES: begin
                  kind_nxt  = RK_CLOCK;
                  tbyte_nxt = {2'b00, in_ch.time_minutes};
                end
                REG_HOURS: begin
                  kind_nxt  = RK_CLOCK;
                  tbyte_nxt = {3'b000, in_ch.time_hours};
                end
                REG_WEEKDAY: begin
                  kind_nxt  = RK_CLOCK;
                  tbyte_nxt = {5'b00000, in_ch.time_weekday};
                end
                REG_DAY: begin
                  kind_nxt  = RK_CLOCK;
                  tbyte_nxt = {3'b000, in_ch.time_day};
                end
                REG_ALARM_S, REG_ALARM_M, REG_ALARM_H: begin
                  kind_nxt = RK_ALARM;
                end
                REG_MONTH: begin
                  kind_nxt  = RK_DATE;
                  tbyte_nxt = {4'h0, in_ch.time_month};
                end
                REG_YEAR: begin
                  kind_nxt  = RK_DATE;
                  tbyte_nxt = in_ch.time_year;
                end
                default: begin
                  kind_nxt = RK_PLAIN;
                end
              endcase
              state_nxt = ST_READ;
            end
            CMD_LOAD: begin
              marks_nxt = default_marks;
              step_nxt  = '0;
              state_nxt = ST_LOAD;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_READ: begin
        // memory data is valid now; wait for a free output register
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_unb_nxt   = 1'b0;
          if (kind_r == RK_CLOCK) begin
            out_data_nxt = tbyte_r;
          end else if (marks_r[idx_a]) begin
            out_data_nxt = ram_rdata;
          end else if (kind_r == RK_PLAIN) begin
            out_data_nxt = 8'h00;
            out_unb_nxt  = 1'b1;
          end else begin
            out_data_nxt = tbyte_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_LOAD: begin
        // one default byte per cycle
        ram_we    = 1'b1;
        ram_waddr = AW'(default_addr(step_r));
        ram_wdata = default_byte(step_r, cfg);
        step_nxt  = step_r + 1'b1;
        if (step_r == DEFAULT_STEP_W'(DEFAULT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_read_goes_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (cmd == CMD_READ) |=> state_r == ST_READ)
    else $error("data read transfer did not enter read state");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_READ)
    else $error("result raised outside read state");

  a_ro_not_written: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && (state_r == ST_IDLE) |->
      (ram_waddr != AW'(REG_STATUS_C)) && (ram_waddr != AW'(REG_STATUS_D)))
    else $error("data write reached a read-only register");

  a_load_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) && (step_r == DEFAULT_STEP_W'(DEFAULT_COUNT - 1))
      |=> state_r == ST_IDLE)
    else $error("defaults sweep overran");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) || (state_r == ST_READ) |-> !in_ch.ready)
    else $error("input accepted while busy");
`endif

endmodule

>>> rtl/cmos_rtc_register_file_top.sv
`timescale 1ns / 1ps

// channel  direction  handshake         payload
// in_ch    sink       valid / ready     command, data, time_* fields
// out_ch   source     valid / ready     read_data, unbacked
// apb      slave      psel/penable      paddr[4:2] register index, pwdata
//
// index write: loads the index; data write: one memory write unless read-only
// data read: registered memory read, then the output register
// load defaults: one memory write per default byte over 15 steps
// reset clears the index and the written marks at once, no clearing pass
// a result waits in the output register; a later read holds until it is free

module cmos_rtc_register_file_top
  import crtc_pkg::*;
#(
  parameter int REG_COUNT = REG_COUNT_DEF,
  localparam int AW       = $clog2(REG_COUNT)
) (
  input  logic        clk,
  input  logic        rst_n,
  crtc_in_if.sink     in_ch,
  crtc_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  crtc_cfg_t   cfg_r;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  ram_rdata;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floppy_count        <= '0;
      cfg_r.floppy_a_type       <= '0;
      cfg_r.floppy_b_type       <= '0;
      cfg_r.disk_count          <= '0;
      cfg_r.base_mem_kb         <= BASE_MEM_RESET;
      cfg_r.ext_mem_kb          <= '0;
      cfg_r.coprocessor_present <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        CFG_FLOPPY_COUNT: cfg_r.floppy_count        <= pwdata[2:0];
        CFG_FLOPPY_A:     cfg_r.floppy_a_type       <= pwdata[3:0];
        CFG_FLOPPY_B:     cfg_r.floppy_b_type       <= pwdata[3:0];
        CFG_DISK_COUNT:   cfg_r.disk_count          <= pwdata[2:0];
        CFG_BASE_MEM:     cfg_r.base_mem_kb         <= pwdata[15:0];
        CFG_EXT_MEM:      cfg_r.ext_mem_kb          <= pwdata[15:0];
        CFG_COPRO:        cfg_r.coprocessor_present <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // register read-back
  always_comb begin
    case (cfg_idx)
      CFG_FLOPPY_COUNT: prdata = {29'd0, cfg_r.floppy_count};
      CFG_FLOPPY_A:     prdata = {28'd0, cfg_r.floppy_a_type};
      CFG_FLOPPY_B:     prdata = {28'd0, cfg_r.floppy_b_type};
      CFG_DISK_COUNT:   prdata = {29'd0, cfg_r.disk_count};
      CFG_BASE_MEM:     prdata = {16'd0, cfg_r.base_mem_kb};
      CFG_EXT_MEM:      prdata = {16'd0, cfg_r.ext_mem_kb};
      CFG_COPRO:        prdata = {31'd0, cfg_r.coprocessor_present};
      default:          prdata = 32'd0;
    endcase
  end

  // sequencer and marks
  crtc_ctrl #(
    .REG_COUNT (REG_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg       (cfg_r),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // register store
  crtc_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

>>> tb/cmos_rtc_register_file_top_test.sv
`timescale 1ns / 1ps

module cmos_rtc_register_file_top_test
  import crtc_pkg::*;
();

  localparam int       PHASES       = 8;
  localparam int       PHASE_ITEMS  = 114;
  localparam int       SETTLE_CYCLES = 24;
  localparam int       DRAIN_GUARD  = 5000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  // one transfer on the input channel
  typedef struct {
    crtc_cmd_t  cmd;
    logic [7:0] data;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [7:0] year;
  } rtc_item_t;

  // one byte returned by a data read
  typedef struct {
    logic [7:0] read_data;
    logic       unbacked;
  } rtc_read_t;

  // register file mirror and the queue of reads still owed by the block
  class rtc_read_scoreboard;
    logic [2:0]       floppy_count;
    logic [3:0]       floppy_a;
    logic [3:0]       floppy_b;
    logic [2:0]       disk_count;
    logic [15:0]      base_kb;
    logic [15:0]      ext_kb;
    logic             copro;
    logic [IDX_W-1:0] index;
    logic [7:0]       store [64];
    bit               marks [64];
    rtc_read_t        pending_reads [$];
    int               errors;
    int               reads_checked;
    int               items_seen;

    function new();
      floppy_count = '0;
      floppy_a     = '0;
      floppy_b     = '0;
      disk_count   = '0;
      base_kb      = 16'd640;
      ext_kb       = '0;
      copro        = 1'b0;
      index        = '0;
      foreach (marks[i]) begin
        marks[i] = 1'b0;
        store[i] = 8'h00;
      end
      errors        = 0;
      reads_checked = 0;
      items_seen    = 0;
    endfunction

    function void set_cfg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        CFG_FLOPPY_COUNT: floppy_count = val[2:0];
        CFG_FLOPPY_A:     floppy_a     = val[3:0];
        CFG_FLOPPY_B:     floppy_b     = val[3:0];
        CFG_DISK_COUNT:   disk_count   = val[2:0];
        CFG_BASE_MEM:     base_kb      = val[15:0];
        CFG_EXT_MEM:      ext_kb       = val[15:0];
        CFG_COPRO:        copro        = val[0];
        default:          ;
      endcase
    endfunction

    function void put(logic [IDX_W-1:0] a, logic [7:0] b);
      store[a] = b;
      marks[a] = 1'b1;
    endfunction

    // defaults sweep: clear every mark then fill the setup bytes
    function void load_defaults();
      logic [2:0] drives;
      foreach (marks[i]) marks[i] = 1'b0;
      if (floppy_count == 3'd0) drives = 3'd0;
      else if (floppy_count > 3'd4) drives = 3'd3;
      else drives = floppy_count - 3'd1;
      put(REG_FLOPPY, {(floppy_count != 3'd0) ? floppy_a : 4'h0,
                       (floppy_count > 3'd1) ? floppy_b : 4'h0});
      put(REG_EQUIP, {drives[1:0], 4'b0000, copro, floppy_count != 3'd0});
      put(REG_DISK, {(disk_count != 3'd0) ? 4'hF : 4'h0,
                     (disk_count > 3'd1) ? 4'hF : 4'h0});
      put(REG_DISK_C, DEF_DISK_TYP);
      put(REG_DISK_D, DEF_DISK_TYP);
      put(REG_STATUS_A, DEF_STATUS_A);
      put(REG_STATUS_B, DEF_STATUS_B);
      put(REG_STATUS_C, DEF_STATUS_C);
      put(REG_STATUS_D, DEF_STATUS_D);
      put(REG_DIAG, DEF_DIAG);
      put(REG_BASE_LO, base_kb[7:0]);
      put(REG_BASE_HI, base_kb[15:8]);
      put(REG_EXT_LO, ext_kb[7:0]);
      put(REG_EXT_HI, ext_kb[15:8]);
      put(REG_CENTURY, DEF_CENTURY);
    endfunction

    function rtc_read_t predict_read(rtc_item_t it);
      rtc_read_t r;
      r.unbacked = 1'b0;
      case (index)
        REG_SECONDS: r.read_data = {2'b00, it.seconds};
        REG_MINUTES: r.read_data = {2'b00, it.minutes};
        REG_HOURS:   r.read_data = {3'b000, it.hours};
        REG_WEEKDAY: r.read_data = {5'b00000, it.weekday};
        REG_DAY:     r.read_data = {3'b000, it.day};
        REG_ALARM_S, REG_ALARM_M, REG_ALARM_H:
          r.read_data = marks[index] ? store[index] : 8'h00;
        REG_MONTH:   r.read_data = marks[index] ? store[index] : {4'h0, it.month};
        REG_YEAR:    r.read_data = marks[index] ? store[index] : it.year;
        default: begin
          if (marks[index]) begin
            r.read_data = store[index];
          end else begin
            r.read_data = 8'h00;
            r.unbacked  = 1'b1;
          end
        end
      endcase
      return r;
    endfunction

    // called once per accepted input transfer
    function void note_transfer(rtc_item_t it);
      items_seen++;
      case (it.cmd)
        CMD_INDEX: index = it.data[IDX_W-1:0];
        CMD_WRITE: if (index != REG_STATUS_C && index != REG_STATUS_D) put(index, it.data);
        CMD_LOAD:  load_defaults();
        default:   pending_reads.push_back(predict_read(it));
      endcase
    endfunction

    // called once per accepted result transfer
    function void check_read(logic [7:0] rd, logic unb);
      rtc_read_t e;
      if (pending_reads.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual data %02h unbacked %0b",
                 $time, rd, unb);
      end else begin
        e = pending_reads.pop_front();
        reads_checked++;
        if (rd !== e.read_data) begin
          errors++;
          $display("%0t read_data mismatch: expected %02h actual %02h",
                   $time, e.read_data, rd);
        end
        if (unb !== e.unbacked) begin
          errors++;
          $display("%0t unbacked mismatch: expected %0b actual %0b",
                   $time, e.unbacked, unb);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crtc_in_if  in_if ();
  crtc_out_if out_if ();

  rtc_read_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  int items_sent;
  int settings_applied;

  cmos_rtc_register_file_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // result side: random back-pressure and checking
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_read(out_if.read_data, out_if.unbacked);
      out_if.ready <= rst_n && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic rtc_item_t make_item(crtc_cmd_t c, logic [7:0] d);
    rtc_item_t it;
    it.cmd     = c;
    it.data    = d;
    it.seconds = 6'($urandom);
    it.minutes = 6'($urandom);
    it.hours   = 5'($urandom);
    it.weekday = 3'($urandom);
    it.day     = 5'($urandom);
    it.month   = 4'($urandom);
    it.year    = 8'($urandom);
    return it;
  endfunction

  // mostly the named registers, sometimes anywhere in the file
  function automatic logic [IDX_W-1:0] rand_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return IDX_W'($urandom_range(0, 'h1B));
    else if (r < 62) return REG_CENTURY;
    else return IDX_W'($urandom_range(0, 63));
  endfunction

  // input transfer with random gaps ahead of it
  task automatic send(input rtc_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= it.cmd;
    in_if.data         <= it.data;
    in_if.time_seconds <= it.seconds;
    in_if.time_minutes <= it.minutes;
    in_if.time_hours   <= it.hours;
    in_if.time_weekday <= it.weekday;
    in_if.time_day     <= it.day;
    in_if.time_month   <= it.month;
    in_if.time_year    <= it.year;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_transfer(it);
    items_sent++;
  endtask

  task automatic send_cmd(input crtc_cmd_t c, input logic [7:0] d);
    send(make_item(c, d));
  endtask

  // index write with random top bits, which the block drops
  task automatic select_reg(input logic [IDX_W-1:0] a);
    logic [1:0] top;
    top = 2'($urandom);
    send_cmd(CMD_INDEX, {top, a});
  endtask

  // data read with every time field at all ones or all zeros
  task automatic read_time(input bit hi);
    rtc_item_t it;
    it         = make_item(CMD_READ, 8'($urandom));
    it.seconds = hi ? '1 : '0;
    it.minutes = hi ? '1 : '0;
    it.hours   = hi ? '1 : '0;
    it.weekday = hi ? '1 : '0;
    it.day     = hi ? '1 : '0;
    it.month   = hi ? '1 : '0;
    it.year    = hi ? '1 : '0;
    send(it);
  endtask

  // stop sending, let every read come back, then let a defaults sweep finish
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_if.valid <= 1'b0;
    while (sb.pending_reads.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_cfg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // field in the low bits, junk above it
  task automatic cfg_field(input logic [2:0] idx, input logic [31:0] val, input int w);
    cfg_write(idx, (32'($urandom) << w) | val);
  endtask

  task automatic apply_phase_cfg(input int p);
    logic [2:0]  fc;
    logic [2:0]  dc;
    logic [3:0]  fa;
    logic [3:0]  fb;
    logic [15:0] bm;
    logic [15:0] em;
    logic        cp;
    fc = 3'($urandom);
    dc = 3'($urandom);
    fa = 4'($urandom);
    fb = 4'($urandom);
    bm = 16'($urandom);
    em = 16'($urandom);
    cp = 1'($urandom);
    case (p)
      0: begin
        fc = '0; dc = '0; fa = '0; fb = '0; bm = '0; em = '0; cp = 1'b0;
      end
      1: begin
        fc = '1; dc = '1; fa = '1; fb = '1; bm = '1; em = '1; cp = 1'b1;
      end
      2: begin
        fc = 3'd1; dc = 3'd1;
      end
      3: begin
        fc = 3'd2; dc = 3'd2;
      end
      4: begin
        fc = 3'd4; dc = 3'd4;
      end
      default: ;
    endcase
    cfg_field(CFG_FLOPPY_COUNT, 32'(fc), 3);
    cfg_field(CFG_FLOPPY_A, 32'(fa), 4);
    cfg_field(CFG_FLOPPY_B, 32'(fb), 4);
    cfg_field(CFG_DISK_COUNT, 32'(dc), 3);
    cfg_field(CFG_BASE_MEM, 32'(bm), 16);
    cfg_field(CFG_EXT_MEM, 32'(em), 16);
    cfg_field(CFG_COPRO, 32'(cp), 1);
    // an address past the last register must change nothing
    if (p == 1) cfg_write(CFG_UNUSED, $urandom);
    settings_applied++;
  endtask

  // mostly select-then-access sequences, some write-then-read pairs, the rest single random commands
  task automatic random_burst(input int quota);
    int start;
    int r;
    int n;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        select_reg(rand_index());
        n = $urandom_range(1, 3);
        repeat (n) send_cmd(CMD_READ, 8'($urandom));
      end else if (r < 60) begin
        select_reg(rand_index());
        send_cmd(CMD_WRITE, 8'($urandom));
        send_cmd(CMD_READ, 8'($urandom));
      end else if (r < 68) begin
        send_cmd(CMD_LOAD, 8'($urandom));
        select_reg(rand_index());
        send_cmd(CMD_READ, 8'($urandom));
      end else if (r < 80) begin
        send_cmd(CMD_WRITE, 8'($urandom));
        send_cmd(CMD_READ, 8'($urandom));
      end else begin
        send_cmd(crtc_cmd_t'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  // stimulus
  initial begin
    sb               = new();
    tx_idle_pct      = 0;
    rx_stall_pct     = 0;
    items_sent       = 0;
    settings_applied = 0;

    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.command      <= CMD_INDEX;
    in_if.data         <= '0;
    in_if.time_seconds <= '0;
    in_if.time_minutes <= '0;
    in_if.time_hours   <= '0;
    in_if.time_weekday <= '0;
    in_if.time_day     <= '0;
    in_if.time_month   <= '0;
    in_if.time_year    <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: live time, unwritten alarm, read-only status, defaults, date
    send_cmd(CMD_INDEX, {2'b11, REG_SECONDS});
    read_time(1'b1);
    read_time(1'b0);
    select_reg(REG_MINUTES);
    read_time(1'b1);
    select_reg(REG_HOURS);
    read_time(1'b1);
    select_reg(REG_WEEKDAY);
    read_time(1'b1);
    select_reg(REG_DAY);
    read_time(1'b1);
    select_reg(REG_MONTH);
    read_time(1'b1);
    select_reg(REG_YEAR);
    read_time(1'b1);
    select_reg(REG_ALARM_S);
    read_time(1'b0);
    select_reg(REG_STATUS_C);
    send_cmd(CMD_WRITE, 8'hFF);
    read_time(1'b0);
    send_cmd(CMD_LOAD, 8'h00);
    read_time(1'b0);
    select_reg(REG_MONTH);
    send_cmd(CMD_WRITE, 8'h00);
    read_time(1'b1);
    select_reg(6'h3F);
    send_cmd(CMD_WRITE, 8'hFF);
    read_time(1'b0);

    // random phases, each with a new setting and one of four idle patterns
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      apply_phase_cfg(p);
      case (p % 4)
        0: begin
          tx_idle_pct = 0; rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct = 75; rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct = 0; rx_stall_pct = 75;
        end
        default: begin
          tx_idle_pct = 13; rx_stall_pct = 13;
        end
      endcase
      random_burst(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.pending_reads.size() != 0) begin
      sb.errors++;
      $display("%0t missing results: expected %0d more actual 0",
               $time, sb.pending_reads.size());
    end
    $display("%0d command transfers, %0d reads checked, %0d configuration settings",
             sb.items_seen, sb.reads_checked, settings_applied);
    $display("idle patterns: none, sender 75%%, receiver 75%%, both 13%%; %0d errors",
             sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
